// ===== sv/pev_pkg.sv =====
// shared constants, codes, types and helpers for the postfix evaluator
`timescale 1ns / 1ps

package pev_pkg;

   // sizing
   localparam int STACK_DEPTH   = 128;
   localparam int NUM_VARIABLES = 26;
   localparam int FRAC_BITS     = 16;

   // payload widths
   localparam int VAL_W    = 48;
   localparam int OP_W     = 2;
   localparam int TOKEN_W  = 8;
   localparam int SLOT_W   = 5;
   localparam int DEPTH_W  = 8;
   localparam int STATUS_W = 3;

   // derived widths
   localparam int SP_W    = $clog2(STACK_DEPTH + 1);
   localparam int STK_AW  = $clog2(STACK_DEPTH);
   localparam int VAR_IW  = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;
   localparam int DIVQ_W  = VAL_W + FRAC_BITS;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int ALU_W   = VAL_W + 2;
   localparam int CNT_W   = $clog2(DIVQ_W + 1);

   // request op codes
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_TOKEN  = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   // token characters
   localparam logic [TOKEN_W-1:0] CHAR_A     = 8'd65;
   localparam logic [TOKEN_W-1:0] CHAR_Z     = 8'd90;
   localparam logic [TOKEN_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [TOKEN_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [TOKEN_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [TOKEN_W-1:0] CHAR_SLASH = 8'h2F;

   // response status codes
   localparam logic [STATUS_W-1:0] STS_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] STS_UNDER = 3'd1;
   localparam logic [STATUS_W-1:0] STS_OVER  = 3'd2;
   localparam logic [STATUS_W-1:0] STS_DIVZ  = 3'd3;
   localparam logic [STATUS_W-1:0] STS_SAT   = 3'd4;

   // saturation limits
   localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_OPND,
      S_ITER,
      S_FINAL,
      S_POP
   } state_type;

   // magnitude of a two's complement word, most negative value maps to 2^(w-1)
   function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] v);
      return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
   endfunction

endpackage

// ===== sv/pev_if.sv =====
// request and response channel interfaces of the postfix evaluator
`timescale 1ns / 1ps

interface pev_req_if import pev_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic [TOKEN_W-1:0]         token;
   logic [SLOT_W-1:0]          slot;
   logic signed [VAL_W-1:0]    value;

   modport source (output valid, op, token, slot, value, input ready);
   modport sink   (input valid, op, token, slot, value, output ready);
endinterface

interface pev_rsp_if import pev_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [VAL_W-1:0]    top_value;
   logic [DEPTH_W-1:0]         depth;
   logic [STATUS_W-1:0]        status;

   modport source (output valid, top_value, depth, status, input ready);
   modport sink   (input valid, top_value, depth, status, output ready);
endinterface

// ===== sv/pev_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pev_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/postfix_expression_evaluator_core.sv =====
// postfix expression evaluator: operand stack, variable table, shared iterative alu
`timescale 1ns / 1ps

// channel   dir  fields                          handshake
// req_ch    in   op, token, slot, value          valid / ready
// rsp_ch    out  top_value, depth, status        valid / ready
//
// finish pops the cached top, and the stack top is refilled from ram in the pop state;
// * and / run iteratively on one shared 50-bit adder, one product or quotient bit per cycle
// (48 multiplier bits for *, a quotient of 48 + FRAC_BITS bits for /)
// one request at a time: req_ch.ready is high only in idle with the response register empty
// the response register holds until taken; a stalled response blocks the next request
// synchronous reset empties the stack and clears the variable table

module postfix_expression_evaluator_core import pev_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   pev_req_if.sink       req_ch,
   pev_rsp_if.source     rsp_ch
);

   // sequencer and stack control
   state_type              state_ff, state_in;
   logic [SP_W-1:0]        sp_ff, sp_in;
   logic [VAL_W-1:0]       top_ff, top_in;       // cached top of stack, ram holds the rest
   logic [VAL_W-1:0]       var_ff [NUM_VARIABLES];
   logic [VAL_W-1:0]       var_in [NUM_VARIABLES];

   // latched request
   logic [OP_W-1:0]        op_ff;
   logic [TOKEN_W-1:0]     tok_ff;
   logic [SLOT_W-1:0]      slot_ff;
   logic [VAL_W-1:0]       val_ff;

   // iterative multiply / divide registers
   logic [VAL_W-1:0]       hi_ff, hi_in;         // partial product high half or remainder
   logic [DIVQ_W-1:0]      lo_ff, lo_in;         // multiplier / dividend shifting into quotient
   logic [VAL_W-1:0]       dvs_ff, dvs_in;       // multiplicand or divisor magnitude
   logic                   neg_ff, neg_in;
   logic                   mul_ff, mul_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]       rsp_top_ff, rsp_top_in;
   logic [DEPTH_W-1:0]     rsp_depth_ff, rsp_depth_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   // stack ram
   logic                   ram_we;
   logic [STK_AW-1:0]      ram_waddr;
   logic [STK_AW-1:0]      ram_raddr;
   logic [VAL_W-1:0]       ram_rdata;

   // shared adder
   logic [ALU_W-1:0]       a_u, b_u, sum_u;
   logic                   sub_u;

   // token decode and helpers
   logic                   req_fire;
   logic                   is_letter, is_arith, is_star, is_slash, is_minus, is_muldiv;
   logic [TOKEN_W-1:0]     letter_idx;
   logic [VAL_W-1:0]       letter_val;
   logic [VAL_W-1:0]       cur_show;
   logic [SP_W-1:0]        sp_m1, sp_m2, sp_p1;
   logic                   iter_last;
   logic                   as_ovf;
   logic [VAL_W-1:0]       as_res;
   logic                   ge_u;
   logic [PROD_W-1:0]      prod_w, mag_x;
   logic                   over_x, sat_f;
   logic [VAL_W-1:0]       res_f;

   assign req_fire = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE) & ~rsp_valid_ff;

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.top_value = rsp_top_ff;
   assign rsp_ch.depth     = rsp_depth_ff;
   assign rsp_ch.status    = rsp_status_ff;

   assign is_letter  = (tok_ff >= CHAR_A) && (tok_ff <= CHAR_Z);
   assign is_star    = (tok_ff == CHAR_STAR);
   assign is_slash   = (tok_ff == CHAR_SLASH);
   assign is_minus   = (tok_ff == CHAR_MINUS);
   assign is_muldiv  = is_star | is_slash;
   assign is_arith   = is_muldiv | is_minus | (tok_ff == CHAR_PLUS);
   assign letter_idx = tok_ff - CHAR_A;
   // letters past the table push zero
   assign letter_val = (letter_idx < TOKEN_W'(NUM_VARIABLES)) ?
                       var_ff[letter_idx[VAR_IW-1:0]] : '0;

   assign cur_show = (sp_ff != '0) ? top_ff : '0;
   assign sp_m1    = sp_ff - SP_W'(1);
   assign sp_m2    = sp_ff - SP_W'(2);
   assign sp_p1    = sp_ff + SP_W'(1);

   // the entry below the cached top, read for operators and for the pop refill
   assign ram_raddr = sp_m2[STK_AW-1:0];
   assign ram_waddr = sp_m1[STK_AW-1:0];

   assign iter_last = (cnt_ff == (mul_ff ? CNT_W'(VAL_W - 1) : CNT_W'(DIVQ_W - 1)));

   pev_ram #(
      .WIDTH (VAL_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (top_ff),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // shared adder operand selection: add/sub, multiply step, divide step
   always_comb begin
      a_u   = '0;
      b_u   = '0;
      sub_u = 1'b0;
      unique case (state_ff)
         S_OPND: begin
            a_u   = {{2{ram_rdata[VAL_W-1]}}, ram_rdata};
            b_u   = {{2{top_ff[VAL_W-1]}}, top_ff};
            sub_u = is_minus;
         end
         S_ITER: begin
            if (mul_ff) begin
               a_u = {2'b00, hi_ff};
               b_u = lo_ff[0] ? {2'b00, dvs_ff} : '0;
            end else begin
               a_u   = {1'b0, hi_ff, lo_ff[DIVQ_W-1]};
               b_u   = {2'b00, dvs_ff};
               sub_u = 1'b1;
            end
         end
         default: begin
            a_u = '0;
         end
      endcase
   end

   assign sum_u = a_u + (sub_u ? ~b_u : b_u) + ALU_W'(sub_u);
   assign ge_u  = ~sum_u[ALU_W-1];

   // add/sub result saturates when the guard bits disagree with the sign
   assign as_ovf = ~((&sum_u[ALU_W-1:VAL_W-1]) | ~(|sum_u[ALU_W-1:VAL_W-1]));
   assign as_res = as_ovf ? (sum_u[ALU_W-1] ? VAL_MIN : VAL_MAX) : sum_u[VAL_W-1:0];

   // final scaling, clamp and sign for multiply and divide
   assign prod_w = {hi_ff, lo_ff[DIVQ_W-1 -: VAL_W]};
   assign mag_x  = mul_ff ? (prod_w >> FRAC_BITS) : PROD_W'(lo_ff);
   assign over_x = |mag_x[PROD_W-1:VAL_W];
   assign sat_f  = over_x | (neg_ff ? (mag_x[VAL_W-1] & (|mag_x[VAL_W-2:0]))
                                    : mag_x[VAL_W-1]);
   assign res_f  = sat_f ? (neg_ff ? VAL_MIN : VAL_MAX)
                         : (neg_ff ? (~mag_x[VAL_W-1:0] + VAL_W'(1)) : mag_x[VAL_W-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if ((op_ff == OP_TOKEN) && !is_letter && is_arith && (sp_ff >= SP_W'(2)) &&
                !(is_slash && (top_ff == '0))) begin
               state_in = S_OPND;
            end else if ((op_ff == OP_FINISH) && (sp_ff != '0)) begin
               state_in = S_POP;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OPND: begin
            state_in = is_muldiv ? S_ITER : S_IDLE;
         end
         S_ITER: begin
            if (iter_last) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            state_in = S_IDLE;
         end
         S_POP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath and response updates
   always_comb begin
      sp_in         = sp_ff;
      top_in        = top_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      dvs_in        = dvs_ff;
      neg_in        = neg_ff;
      mul_in        = mul_ff;
      cnt_in        = cnt_ff;
      ram_we        = 1'b0;
      var_in        = var_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_top_in    = rsp_top_ff;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_EXEC: begin
            rsp_valid_in  = 1'b1;
            rsp_top_in    = cur_show;
            rsp_depth_in  = DEPTH_W'(sp_ff);
            rsp_status_in = STS_OK;
            unique case (op_ff)
               OP_LOAD: begin
                  // slots past the table are dropped
                  for (int i = 0; i < NUM_VARIABLES; i++) begin
                     if (slot_ff == SLOT_W'(i)) begin
                        var_in[i] = val_ff;
                     end
                  end
               end
               OP_TOKEN: begin
                  if (is_letter) begin
                     if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                        rsp_status_in = STS_OVER;
                     end else begin
                        // spill the cached top into ram, new value becomes the top
                        ram_we       = (sp_ff != '0);
                        top_in       = letter_val;
                        sp_in        = sp_p1;
                        rsp_top_in   = letter_val;
                        rsp_depth_in = DEPTH_W'(sp_p1);
                     end
                  end else if (is_arith) begin
                     if (sp_ff < SP_W'(2)) begin
                        rsp_status_in = STS_UNDER;
                     end else if (is_slash && (top_ff == '0)) begin
                        rsp_status_in = STS_DIVZ;
                     end else begin
                        // left operand still to come from ram
                        rsp_valid_in = 1'b0;
                     end
                  end
               end
               OP_FINISH: begin
                  if (sp_ff == '0) begin
                     rsp_status_in = STS_UNDER;
                  end else begin
                     sp_in        = sp_m1;
                     rsp_top_in   = top_ff;
                     rsp_depth_in = DEPTH_W'(sp_m1);
                  end
               end
               default: begin
                  rsp_status_in = STS_OK;
               end
            endcase
         end
         S_OPND: begin
            if (is_muldiv) begin
               hi_in  = '0;
               lo_in  = is_star ? DIVQ_W'(mag_of(ram_rdata))
                                : (DIVQ_W'(mag_of(ram_rdata)) << FRAC_BITS);
               dvs_in = mag_of(top_ff);
               neg_in = ram_rdata[VAL_W-1] ^ top_ff[VAL_W-1];
               mul_in = is_star;
               cnt_in = '0;
            end else begin
               top_in        = as_res;
               sp_in         = sp_m1;
               rsp_valid_in  = 1'b1;
               rsp_top_in    = as_res;
               rsp_depth_in  = DEPTH_W'(sp_m1);
               rsp_status_in = as_ovf ? STS_SAT : STS_OK;
            end
         end
         S_ITER: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (mul_ff) begin
               // shift-add, multiplier bits consumed from the bottom
               hi_in = sum_u[VAL_W:1];
               lo_in = {sum_u[0], lo_ff[DIVQ_W-1:1]};
            end else begin
               // restoring divide, one quotient bit per cycle
               hi_in = ge_u ? sum_u[VAL_W-1:0] : {hi_ff[VAL_W-2:0], lo_ff[DIVQ_W-1]};
               lo_in = {lo_ff[DIVQ_W-2:0], ge_u};
            end
         end
         S_FINAL: begin
            top_in        = res_f;
            sp_in         = sp_m1;
            rsp_valid_in  = 1'b1;
            rsp_top_in    = res_f;
            rsp_depth_in  = DEPTH_W'(sp_m1);
            rsp_status_in = sat_f ? STS_SAT : STS_OK;
         end
         S_POP: begin
            // refill the cached top after a finish pop
            top_in = ram_rdata;
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_VARIABLES; i++) begin
            var_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
         var_ff       <= var_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= req_ch.op;
         tok_ff  <= req_ch.token;
         slot_ff <= req_ch.slot;
         val_ff  <= req_ch.value;
      end
      top_ff        <= top_in;
      hi_ff         <= hi_in;
      lo_ff         <= lo_in;
      dvs_ff        <= dvs_in;
      neg_ff        <= neg_in;
      mul_ff        <= mul_in;
      cnt_ff        <= cnt_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== dv/postfix_expression_evaluator_core_test.sv =====
// self-checking testbench for the postfix expression evaluator core
`timescale 1ns / 1ps

module postfix_expression_evaluator_core_test;
   import pev_pkg::*;

   // the fourth op code has no name in the package, the core ignores it
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   localparam int  QUIET_TAIL  = 150;    // requests left when idling stops
   localparam int  HOLD_START  = 2000;   // cycle of the long response hold-off
   localparam int  HOLD_LEN    = 300;
   localparam int  DRAIN_WAIT  = 100;    // longer than the slowest divide
   localparam int  RUN_ITEMS   = 1600;
   localparam int  MAX_REPORTS = 10;

   localparam longint LONG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint LONG_MIN = -LONG_MAX - 1;

   typedef struct {
      logic [OP_W-1:0]     op;
      logic [TOKEN_W-1:0]  token;
      logic [SLOT_W-1:0]   slot;
      logic [VAL_W-1:0]    value;
   } request_type;

   // what the core should answer for one request
   typedef struct {
      logic [VAL_W-1:0]    top_value;
      logic [DEPTH_W-1:0]  depth;
      logic [STATUS_W-1:0] status;
      int                  seq;
   } stack_report_type;

   logic clock;
   logic reset;

   pev_req_if req_ch ();
   pev_rsp_if rsp_ch ();

   postfix_expression_evaluator_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // postfix program waiting to be sent, and stack reports waiting to come back
   request_type      program_q[$];
   stack_report_type report_q[$];

   // shadow copy of the evaluator state
   logic [VAL_W-1:0] shadow_vars  [NUM_VARIABLES];
   logic [VAL_W-1:0] shadow_stack [STACK_DEPTH];
   int               shadow_sp;

   int   mismatch_cnt;
   int   accepted_cnt;
   int   send_gap;
   int   stall_left;
   int   cycle_cnt;
   int   hold_left;
   logic quiet;

   // ---------------------------------------------------------------------------
   // clock and reset
   // ---------------------------------------------------------------------------
   initial begin : clock_gen
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : reset_gen
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // saturation helpers for the shadow arithmetic
   // ---------------------------------------------------------------------------

   // clamp an exact sum or difference into the 48-bit range
   function automatic logic [VAL_W-1:0] clamp_long(input longint v, inout bit sat);
      if (v > LONG_MAX) begin
         sat = 1'b1;
         return VAL_MAX;
      end
      if (v < LONG_MIN) begin
         sat = 1'b1;
         return VAL_MIN;
      end
      return v[VAL_W-1:0];
   endfunction

   // rebuild a signed word from sign and magnitude, clamping at the limits
   function automatic logic [VAL_W-1:0] clamp_mag(input bit neg, input logic [PROD_W-1:0] m,
                                                   inout bit sat);
      if (neg) begin
         if (m > PROD_W'(VAL_MIN)) begin
            sat = 1'b1;
            return VAL_MIN;
         end
         return VAL_W'(0) - m[VAL_W-1:0];
      end
      if (m > PROD_W'(VAL_MAX)) begin
         sat = 1'b1;
         return VAL_MAX;
      end
      return m[VAL_W-1:0];
   endfunction

   // ---------------------------------------------------------------------------
   // shadow evaluator: applies one request, returns the stack report
   // ---------------------------------------------------------------------------
   function automatic stack_report_type apply_request(input logic [OP_W-1:0] op,
                                                      input logic [TOKEN_W-1:0] tok,
                                                      input logic [SLOT_W-1:0] slot,
                                                      input logic [VAL_W-1:0] val);
      stack_report_type  rep;
      longint            lhs;
      longint            rhs;
      logic [PROD_W-1:0] mag_l;
      logic [PROD_W-1:0] mag_r;
      logic [VAL_W-1:0]  res;
      bit                sat;
      bit                popped;
      int                idx;

      rep.status    = STS_OK;
      rep.top_value = '0;
      rep.seq       = 0;
      sat           = 1'b0;
      popped        = 1'b0;
      res           = '0;

      case (op)
         OP_LOAD: begin
            // slots beyond the table are dropped silently
            if (slot < NUM_VARIABLES) shadow_vars[slot] = val;
         end
         OP_TOKEN: begin
            if (tok >= CHAR_A && tok <= CHAR_Z) begin
               idx = int'(tok) - int'(CHAR_A);
               if (shadow_sp >= STACK_DEPTH) begin
                  rep.status = STS_OVER;
               end else begin
                  shadow_stack[shadow_sp] = (idx < NUM_VARIABLES) ? shadow_vars[idx] : '0;
                  shadow_sp++;
               end
            end else if (tok == CHAR_PLUS || tok == CHAR_MINUS ||
                         tok == CHAR_STAR || tok == CHAR_SLASH) begin
               if (shadow_sp < 2) begin
                  rep.status = STS_UNDER;
               end else begin
                  // top of stack is the right operand
                  lhs = $signed(shadow_stack[shadow_sp-2]);
                  rhs = $signed(shadow_stack[shadow_sp-1]);
                  if (tok == CHAR_SLASH && rhs == 0) begin
                     // both operands stay in place
                     rep.status = STS_DIVZ;
                  end else begin
                     mag_l = PROD_W'(lhs < 0 ? -lhs : lhs);
                     mag_r = PROD_W'(rhs < 0 ? -rhs : rhs);
                     if (tok == CHAR_PLUS)
                        res = clamp_long(lhs + rhs, sat);
                     else if (tok == CHAR_MINUS)
                        res = clamp_long(lhs - rhs, sat);
                     else if (tok == CHAR_STAR)
                        res = clamp_mag((lhs < 0) != (rhs < 0),
                                        (mag_l * mag_r) >> FRAC_BITS, sat);
                     else
                        res = clamp_mag((lhs < 0) != (rhs < 0),
                                        (mag_l << FRAC_BITS) / mag_r, sat);
                     shadow_sp--;
                     shadow_stack[shadow_sp-1] = res;
                     if (sat) rep.status = STS_SAT;
                  end
               end
            end
            // any other character leaves everything alone
         end
         OP_FINISH: begin
            if (shadow_sp == 0) begin
               rep.status = STS_UNDER;
            end else begin
               shadow_sp--;
               rep.top_value = shadow_stack[shadow_sp];
               popped        = 1'b1;
            end
         end
         default: ;
      endcase

      if (!popped && shadow_sp > 0) rep.top_value = shadow_stack[shadow_sp-1];
      rep.depth = DEPTH_W'(shadow_sp);
      return rep;
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------

   // value mix: mostly small fixed-point numbers, some full-range words and limits
   function automatic logic [VAL_W-1:0] rand_value();
      logic [63:0]      raw;
      logic [VAL_W-1:0] m;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            m = (VAL_W'($urandom_range(0, 200)) << FRAC_BITS) | VAL_W'(raw[15:0]);
            return raw[16] ? VAL_W'(0) - m : m;
         end
         4, 5: return raw[VAL_W-1:0];
         6: begin
            case ($urandom_range(0, 6))
               0: return VAL_MAX;
               1: return VAL_MIN;
               2: return '0;
               3: return VAL_W'(1);
               4: return '1;
               5: return VAL_W'(1) << FRAC_BITS;
               default: return VAL_W'(0) - (VAL_W'(1) << FRAC_BITS);
            endcase
         end
         7, 8: return {{(VAL_W-32){raw[31]}}, raw[31:0]};
         default: begin
            m = VAL_W'($urandom_range(1, 8)) << FRAC_BITS;
            return raw[20] ? VAL_W'(0) - m : m;
         end
      endcase
   endfunction

   function automatic logic [TOKEN_W-1:0] rand_operator();
      case ($urandom_range(0, 3))
         0: return CHAR_PLUS;
         1: return CHAR_MINUS;
         2: return CHAR_STAR;
         default: return CHAR_SLASH;
      endcase
   endfunction

   function automatic logic [TOKEN_W-1:0] rand_letter();
      return CHAR_A + TOKEN_W'($urandom_range(0, 25));
   endfunction

   // unused fields of every token, load and finish request carry random bits
   task automatic push_req(input logic [OP_W-1:0] op, input logic [TOKEN_W-1:0] tok,
                           input logic [SLOT_W-1:0] slot, input logic [VAL_W-1:0] val);
      request_type r;
      r.op    = op;
      r.token = tok;
      r.slot  = slot;
      r.value = val;
      program_q.push_back(r);
   endtask

   task automatic push_token(input logic [TOKEN_W-1:0] tok);
      push_req(OP_TOKEN, tok, SLOT_W'($urandom), VAL_W'({$urandom, $urandom}));
   endtask

   task automatic push_load(input logic [SLOT_W-1:0] slot, input logic [VAL_W-1:0] val);
      push_req(OP_LOAD, TOKEN_W'($urandom), slot, val);
   endtask

   task automatic push_finish();
      push_req(OP_FINISH, TOKEN_W'($urandom), SLOT_W'($urandom),
               VAL_W'({$urandom, $urandom}));
   endtask

   // ---------------------------------------------------------------------------
   // program generation
   // ---------------------------------------------------------------------------
   initial begin : program_gen
      int live;
      int len;
      int fills;

      fills = 0;

      // directed opening: underflow, limits, saturation, divide by zero, ignored input
      push_finish();                        // finish on an empty stack
      push_token(CHAR_PLUS);                // operator with nothing to pop
      push_load(5'd0, VAL_MAX);
      push_load(5'd1, VAL_MIN);
      push_load(5'd2, '0);
      push_load(5'd3, VAL_W'(1) << FRAC_BITS);
      push_load(5'd31, rand_value());       // slot past the table
      push_token(CHAR_A);
      push_token(CHAR_A);
      push_token(CHAR_PLUS);                // max + max saturates
      push_token(CHAR_A + 8'd1);
      push_token(CHAR_MINUS);               // max - min saturates
      push_token(CHAR_A + 8'd2);
      push_token(CHAR_SLASH);               // divide by zero keeps both
      push_token(CHAR_STAR);                // times zero
      push_token(CHAR_A + 8'd1);
      push_token(CHAR_A + 8'd3);
      push_token(CHAR_SLASH);               // min / 1.0 stays exact
      push_token(CHAR_A + 8'd1);
      push_token(CHAR_STAR);                // min * min saturates high
      push_token(8'h23);                    // ignored character
      push_req(OP_SPARE, 8'hFF, 5'h1F, '1); // spare op code
      push_finish();
      push_finish();
      push_finish();                        // empties, then underflows

      while (program_q.size() < RUN_ITEMS) begin
         if ((fills == 0 && program_q.size() >= 500) ||
             (fills == 1 && program_q.size() >= 1100)) begin
            // run the stack past full, then pop it dry
            fills++;
            repeat (STACK_DEPTH + 3) push_token(rand_letter());
            repeat (STACK_DEPTH + 5) push_finish();
            continue;
         end
         case ($urandom_range(0, 99)) inside
            [0:59]: begin
               // well-formed expression with fresh variables
               repeat ($urandom_range(0, 3))
                  push_load(SLOT_W'($urandom_range(0, NUM_VARIABLES - 1)), rand_value());
               len  = $urandom_range(2, 8);
               live = 0;
               for (int k = 0; k < len; k++) begin
                  push_token(rand_letter());
                  live++;
                  while (live >= 2 && $urandom_range(0, 2) == 0) begin
                     push_token(rand_operator());
                     live--;
                  end
               end
               while (live > 1) begin
                  push_token(rand_operator());
                  live--;
               end
               if ($urandom_range(0, 3) != 0) push_finish();
            end
            [60:69]: begin
               // raw noise over every field
               repeat ($urandom_range(1, 4))
                  push_req(OP_W'($urandom_range(0, 3)), TOKEN_W'($urandom),
                           SLOT_W'($urandom), VAL_W'({$urandom, $urandom}));
            end
            [70:79]: begin
               repeat ($urandom_range(1, 5))
                  push_load(SLOT_W'($urandom_range(0, 31)), rand_value());
            end
            [80:87]: begin
               repeat ($urandom_range(1, 5)) push_finish();
            end
            default: begin
               // broken sequence: letters and operators out of balance
               repeat ($urandom_range(2, 8)) begin
                  if ($urandom_range(0, 1) == 0) push_token(rand_letter());
                  else push_token(rand_operator());
               end
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      request_type      nxt;
      stack_report_type rep;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.op    <= OP_LOAD;
         req_ch.token <= '0;
         req_ch.slot  <= '0;
         req_ch.value <= '0;
         quiet        <= 1'b0;
         send_gap      = 0;
         accepted_cnt  = 0;
         shadow_sp     = 0;
         for (int i = 0; i < NUM_VARIABLES; i++) shadow_vars[i] = '0;
      end else begin
         // request taken at this edge: predict its report
         if (req_ch.valid && req_ch.ready) begin
            rep     = apply_request(req_ch.op, req_ch.token, req_ch.slot, req_ch.value);
            rep.seq = accepted_cnt;
            accepted_cnt++;
            report_q.push_back(rep);
         end
         quiet <= (program_q.size() < QUIET_TAIL);

         // a request still on offer stays put
         if (!(req_ch.valid && !req_ch.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (program_q.size() != 0 && !quiet && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 6);
               req_ch.valid <= 1'b0;
            end else if (program_q.size() != 0) begin
               nxt = program_q.pop_front();
               req_ch.op    <= nxt.op;
               req_ch.token <= nxt.token;
               req_ch.slot  <= nxt.slot;
               req_ch.value <= nxt.value;
               req_ch.valid <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // long response hold-off, so the core sits on a finished request
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_hold_off
      if (reset) begin
         cycle_cnt <= 0;
         hold_left <= 0;
      end else begin
         cycle_cnt <= cycle_cnt + 1;
         if (cycle_cnt == HOLD_START) hold_left <= HOLD_LEN;
         else if (hold_left != 0) hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------------
   // response monitor and checker
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      stack_report_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left    = 0;
         mismatch_cnt  = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (report_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MAX_REPORTS)
                  $display("%0t: response with no request pending: top %h depth %0d status %0d",
                           $realtime, rsp_ch.top_value, rsp_ch.depth, rsp_ch.status);
            end else begin
               want = report_q.pop_front();
               if (rsp_ch.top_value !== want.top_value || rsp_ch.depth !== want.depth ||
                   rsp_ch.status !== want.status) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= MAX_REPORTS)
                     $display("%0t: request %0d: top %h/%h depth %0d/%0d status %0d/%0d (exp/got)",
                              $realtime, want.seq, want.top_value, rsp_ch.top_value,
                              want.depth, rsp_ch.depth, want.status, rsp_ch.status);
               end
            end
         end

         // ready: long hold-off first, then random stall bursts, none in the tail
         if (hold_left != 0) begin
            rsp_ch.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // end of run
   // ---------------------------------------------------------------------------
   initial begin : run_end
      @(negedge clock);
      while (reset || program_q.size() != 0 || req_ch.valid || report_q.size() != 0)
         @(negedge clock);
      // let any stray response show up
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_cnt == 0 && report_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
